@@ design/wildcard_byte_pattern_scanner_top_assert.svh @@
// assertion macros shared by the scanner rtl
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_TOP_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_TOP_ASSERT_SVH

// same-cycle implication
`define WBPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner assertion failed");

// next-cycle implication
`define WBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner assertion failed");

`endif

@@ design/wbps_pkg.sv @@
`default_nettype none
package wbps_pkg;

   localparam int PATTERN_MAX = 32;
   localparam int REG_BYTES   = 32;
   localparam int LEN_W       = 6;
   localparam int COUNT_W     = 32;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;

   localparam int SHIFT_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   typedef logic [PATTERN_MAX-1:0][7:0] window_type;
   typedef logic [PATTERN_MAX-1:0]      care_type;

   typedef enum logic [2:0] {
      REG_LENGTH = 3'd0,
      REG_WORD_0 = 3'd1,
      REG_WORD_1 = 3'd2,
      REG_WORD_2 = 3'd3,
      REG_WORD_3 = 3'd4,
      REG_CARE   = 3'd5
   } reg_index_type;

endpackage
`default_nettype wire

@@ design/wbps_match.sv @@
`default_nettype none
module wbps_match import wbps_pkg::*; (
   input  wire window_type                 window,
   input  wire logic [REG_BYTES-1:0][7:0]  pattern,
   input  wire logic [REG_BYTES-1:0]       care,
   input  wire logic [LEN_W-1:0]           length,
   output logic                            match
);

   window_type           rev_pat;
   care_type             rev_care;
   window_type           aligned_pat;
   care_type             aligned_care;
   logic [LEN_W:0]       shift_full;
   logic [SHIFT_W-1:0]   shift_amt;
   logic [PATTERN_MAX-1:0] byte_ok;
   logic                 len_ok;

   // reverse the pattern so that its last byte lines up with the newest window byte
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (i < REG_BYTES) begin
            rev_pat[PATTERN_MAX-1-i]  = pattern[i];
            rev_care[PATTERN_MAX-1-i] = care[i];
         end else begin
            rev_pat[PATTERN_MAX-1-i]  = 8'h00;
            rev_care[PATTERN_MAX-1-i] = 1'b0;
         end
      end
   end

   assign len_ok     = (length != '0) && ({1'b0, length} <= (LEN_W+1)'(PATTERN_MAX));
   assign shift_full = (LEN_W+1)'(PATTERN_MAX) - {1'b0, length};
   assign shift_amt  = shift_full[SHIFT_W-1:0];

   // bytes shifted in from the top are wildcards, so unused window bytes never fail
   assign aligned_pat  = rev_pat >> {shift_amt, 3'b000};
   assign aligned_care = rev_care >> shift_amt;

   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         byte_ok[j] = !aligned_care[j] || (window[j] == aligned_pat[j]);
      end
   end

   assign match = len_ok && (&byte_ok);

endmodule
`default_nettype wire

@@ design/wildcard_byte_pattern_scanner_top.sv @@
// a result is registered and is on rsp in the cycle after the request that produced it is accepted
// throughput: one request per cycle; the single output register is refilled on the
// cycle it is taken, so req_tready only drops while a result waits unclaimed
// the compare is one masked 32-byte match against the shifted window, then a register
// reset: synchronous active high, clears the window, byte count, done flag,
// pattern registers and the output valid
`default_nettype none
module wildcard_byte_pattern_scanner_top import wbps_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] data_byte
   input  wire logic                  req_tlast,   // last_byte
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [COUNT_W-1:0]         rsp_tdata,   // [31:0] match_offset
   output logic                       rsp_tuser,   // [0] found
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic [LEN_W-1:0]             length_ff, length_in;
   logic [REG_BYTES-1:0][7:0]    pattern_ff, pattern_in;
   logic [REG_BYTES-1:0]         care_ff, care_in;

   window_type                   window_ff, window_in, window_shift;
   logic [COUNT_W-1:0]           count_ff, count_in, count_next;
   logic                         done_ff, done_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]           rsp_offset_ff, rsp_offset_in;

   logic                         req_fire, rsp_fire, csr_write;
   logic                         window_match, hit, load_rsp;
   reg_index_type                csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_comb begin
      length_in  = length_ff;
      pattern_in = pattern_ff;
      care_in    = care_ff;
      if (csr_write) begin
         case (csr_index)
            REG_LENGTH: length_in = csr_pwdata[LEN_W-1:0];
            REG_WORD_0: pattern_in[7:0]   = csr_pwdata;
            REG_WORD_1: pattern_in[15:8]  = csr_pwdata;
            REG_WORD_2: pattern_in[23:16] = csr_pwdata;
            REG_WORD_3: pattern_in[31:24] = csr_pwdata;
            REG_CARE:   care_in = csr_pwdata[REG_BYTES-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LENGTH: csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, length_ff};
         REG_WORD_0: csr_prdata = pattern_ff[7:0];
         REG_WORD_1: csr_prdata = pattern_ff[15:8];
         REG_WORD_2: csr_prdata = pattern_ff[23:16];
         REG_WORD_3: csr_prdata = pattern_ff[31:24];
         REG_CARE:   csr_prdata = {{(CSR_DATA_W-REG_BYTES){1'b0}}, care_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign window_shift = {window_ff[PATTERN_MAX-2:0], req_tdata};
   assign count_next   = (count_ff == '1) ? count_ff : count_ff + 1'b1;

   wbps_match u_match (
      .window  (window_shift),
      .pattern (pattern_ff),
      .care    (care_ff),
      .length  (length_ff),
      .match   (window_match)
   );

   assign hit      = !done_ff && window_match &&
                     (count_next >= {{(COUNT_W-LEN_W){1'b0}}, length_ff});
   assign load_rsp = req_fire && (hit || (req_tlast && !done_ff));

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      done_in   = done_ff;
      if (req_fire) begin
         if (req_tlast) begin
            // end of range clears the window, byte count and done flag for the next one
            window_in = '0;
            count_in  = '0;
            done_in   = 1'b0;
         end else begin
            window_in = window_shift;
            count_in  = count_next;
            done_in   = done_ff || hit;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_fire;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = hit;
         rsp_offset_in = hit ? count_next - {{(COUNT_W-LEN_W){1'b0}}, length_ff} : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         pattern_ff   <= '0;
         care_ff      <= '0;
         window_ff    <= '0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         pattern_ff   <= pattern_in;
         care_ff      <= care_in;
         window_ff    <= window_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_offset_ff;
   assign rsp_tuser  = rsp_found_ff;

`include "wildcard_byte_pattern_scanner_top_assert.svh"

   // a match inside a range must latch the done flag
   `WBPS_ASSERT_NEXT(a_hit_sets_done, clock, reset, req_fire && hit && !req_tlast, done_ff)
   // a not-found result only comes from the last byte of a range
   `WBPS_ASSERT_NOW(a_miss_only_last, clock, reset, load_rsp && !hit, req_tlast)
   // no result is loaded over one still waiting
   `WBPS_ASSERT_NOW(a_no_overwrite, clock, reset, load_rsp, !rsp_valid_ff || rsp_tready)
   // a not-found result carries a zero offset
   `WBPS_ASSERT_NEXT(a_miss_zero, clock, reset, load_rsp && !hit, rsp_offset_ff == '0)

endmodule
`default_nettype wire
